// ===== src/crc16_framed_reading_receiver_defines.svh =====
// Assertion macros shared by the receiver RTL.
// ASSERT_IMPL: same-cycle implication, ASSERT_NEXT: next-cycle implication.
`ifndef CRC16_FRAMED_READING_RECEIVER_DEFINES_SVH
`define CRC16_FRAMED_READING_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define CRC16FR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CRC16FR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRC16FR_ASSERT_IMPL(lbl, ante, cons, msg)
`define CRC16FR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/crc16fr_pkg.sv =====
`timescale 1ns / 1ps
package crc16fr_pkg;

	localparam int PosW = 4;
	localparam logic [PosW-1:0] FrameLen     = 4'd11;
	localparam logic [PosW-1:0] PosAddr      = 4'd0;
	localparam logic [PosW-1:0] PosFunc      = 4'd1;
	localparam logic [PosW-1:0] PosReadFirst = 4'd5;
	localparam logic [PosW-1:0] PosCrcLast   = 4'd8;
	localparam logic [PosW-1:0] PosCrcLow    = 4'd9;
	localparam logic [PosW-1:0] PosCrcHigh   = 4'd10;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	localparam logic [7:0] AddrReset = 8'h03;
	localparam logic [7:0] FuncReset = 8'h31;

	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t RegAddr = 1'b0;
	localparam cfg_index_t RegFunc = 1'b1;

	typedef logic [1:0] frame_status_t;
	localparam frame_status_t StatusOk     = 2'd0;
	localparam frame_status_t StatusHeader = 2'd1;
	localparam frame_status_t StatusCrc    = 2'd2;

	localparam int OutTdataW = 40;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/crc16_framed_reading_receiver.sv =====
// Modbus RTU style response receiver with CRC-16 check.
// s_axis: one received byte per item in tdata[7:0], arrival order.
// Bytes are grouped into fixed 11-byte frames: address, function, payload,
// reading in bytes 5..8 (big-endian, signed), CRC low in byte 9, high in 10.
// m_axis: one item per frame, tdata[1:0] status (0 ok, 1 header, 2 CRC),
// tdata[33:2] reading (zero unless status is ok), upper bits zero.
// cfg: write channel, index 0 expected address, index 1 expected function;
// always ready. Write only while no frame byte is in flight.
// Throughput: one byte per cycle while s_axis_tready is high. Each byte passes an
// input register, then an unrolled byte-wide CRC step updates the frame state.
// The result register loads as the 11th byte leaves the input register.
// When m_axis stalls, the result register holds; bytes keep flowing until
// a byte that completes a frame meets a still-full result register, then
// s_axis_tready drops until the result is taken.
// Reset: frame position returns to byte 0, CRC to FFFF, registers to their
// defaults (address 03, function 31), no result pending.
`timescale 1ns / 1ps
`include "crc16_framed_reading_receiver_defines.svh"
module crc16_framed_reading_receiver
	import crc16fr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OutTdataW-1:0] m_axis_tdata,   // [1:0] frame_status, [33:2] reading
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_index_t           cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]          addr_q, func_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [PosW-1:0]     pos_q;
	logic [15:0]         crc_q;
	logic                hdr_q;
	logic [31:0]         shift_q;
	logic                low_q;
	logic                out_valid_q;
	frame_status_t       status_q;
	logic signed [31:0]  reading_q;

	logic                restart;
	logic [PosW-1:0]     pos_cur;
	logic [15:0]         crc_cur, crc_n;
	logic                hdr_cur, hdr_n;
	logic [31:0]         shift_cur, shift_n;
	logic                low_cur, low_n;
	logic                emit_s1, out_free, s1_go, crc_ok;
	frame_status_t       status_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= AddrReset;
			func_q <= FuncReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegAddr: addr_q <= cfg_data;
				RegFunc: func_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unreachable positions fall back to a fresh frame
	assign restart   = (pos_q >= FrameLen);
	assign pos_cur   = restart ? PosAddr : pos_q;
	assign crc_cur   = restart ? CrcInit : crc_q;
	assign hdr_cur   = restart ? 1'b1 : hdr_q;
	assign shift_cur = restart ? 32'd0 : shift_q;
	assign low_cur   = restart ? 1'b0 : low_q;

	assign emit_s1  = (pos_cur == PosCrcHigh);
	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_go    = valid_s1 && (!emit_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;

	always_comb begin
		hdr_n = hdr_cur;
		if (pos_cur == PosAddr && byte_s1 != addr_q) hdr_n = 1'b0;
		if (pos_cur == PosFunc && byte_s1 != func_q) hdr_n = 1'b0;
		crc_n   = (pos_cur <= PosCrcLast) ? crc_byte(crc_cur, byte_s1) : crc_cur;
		shift_n = (pos_cur >= PosReadFirst && pos_cur <= PosCrcLast) ?
			{shift_cur[23:0], byte_s1} : shift_cur;
		low_n   = (pos_cur == PosCrcLow) ? (byte_s1 == crc_cur[7:0]) : low_cur;
		crc_ok  = low_cur && (byte_s1 == crc_cur[15:8]);
		priority if (!hdr_cur) begin
			status_n = StatusHeader;
		end else if (!crc_ok) begin
			status_n = StatusCrc;
		end else begin
			status_n = StatusOk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= PosAddr;
			crc_q   <= CrcInit;
			hdr_q   <= 1'b1;
			shift_q <= 32'd0;
			low_q   <= 1'b0;
		end else if (s1_go) begin
			if (emit_s1) begin
				pos_q   <= PosAddr;
				crc_q   <= CrcInit;
				hdr_q   <= 1'b1;
				shift_q <= 32'd0;
				low_q   <= 1'b0;
			end else begin
				pos_q   <= pos_cur + 4'd1;
				crc_q   <= crc_n;
				hdr_q   <= hdr_n;
				shift_q <= shift_n;
				low_q   <= low_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1) begin
			status_q  <= status_n;
			reading_q <= (status_n == StatusOk) ? $signed(shift_cur) : 32'sd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, reading_q, status_q};

	`CRC16FR_ASSERT_IMPL(a_pos_range, 1'b1, pos_q < FrameLen, "frame position out of range")
	`CRC16FR_ASSERT_IMPL(a_err_zero, out_valid_q && status_q != StatusOk, reading_q == 32'sd0,
		"reading not zero on error")
	`CRC16FR_ASSERT_IMPL(a_status_code, out_valid_q, status_q != 2'd3, "bad status code")
	`CRC16FR_ASSERT_NEXT(a_emit_valid, s1_go && emit_s1, out_valid_q, "result lost")
	`CRC16FR_ASSERT_NEXT(a_emit_restart, s1_go && emit_s1, pos_q == PosAddr && crc_q == CrcInit,
		"frame not restarted")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
	import crc16fr_pkg::*;
;

	localparam int WatchdogLimit = 3000;
	localparam int HoldCycles    = 400;
	localparam int SettleCycles  = 8;
	localparam int SegmentBytes  = 240;

	typedef struct packed {
		frame_status_t status;
		logic [31:0]   reading;
	} frame_result_t;

	typedef enum {FrGood, FrBadHeader, FrBadCrc, FrBadBoth, FrCut} frame_kind_t;

	class frame_checker;
		logic [7:0]      want_addr;
		logic [7:0]      want_func;
		logic [PosW-1:0] pos;
		logic [15:0]     crc;
		bit              hdr_ok;
		logic [31:0]     shift;
		bit              low_ok;
		frame_result_t   awaited[$];
		int              mismatches;
		int              results_seen;
		int              status_count[3];

		function new();
			want_addr = AddrReset;
			want_func = FuncReset;
			restart();
		endfunction

		function void restart();
			pos    = '0;
			crc    = CrcInit;
			hdr_ok = 1'b1;
			shift  = '0;
			low_ok = 1'b0;
		endfunction

		static function logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
			logic [15:0] r;
			r = acc ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
			return r;
		endfunction

		function void set_reg(input cfg_index_t idx, input logic [7:0] v);
			if (idx == RegAddr) begin
				want_addr = v;
			end else if (idx == RegFunc) begin
				want_func = v;
			end
		endfunction

		function void note_byte(input logic [7:0] b);
			frame_result_t r;
			if (pos >= FrameLen) begin
				restart();
			end
			if (pos == PosAddr && b != want_addr) begin
				hdr_ok = 1'b0;
			end
			if (pos == PosFunc && b != want_func) begin
				hdr_ok = 1'b0;
			end
			if (pos <= PosCrcLast) begin
				crc = crc_step(crc, b);
			end
			if (pos >= PosReadFirst && pos <= PosCrcLast) begin
				shift = {shift[23:0], b};
			end
			if (pos == PosCrcLow) begin
				low_ok = (b == crc[7:0]);
			end
			if (pos == PosCrcHigh) begin
				if (!hdr_ok) begin
					r.status = StatusHeader;
				end else if (low_ok && b == crc[15:8]) begin
					r.status = StatusOk;
				end else begin
					r.status = StatusCrc;
				end
				r.reading = (r.status == StatusOk) ? shift : 32'd0;
				awaited.push_back(r);
				restart();
			end else begin
				pos = pos + 1'b1;
			end
		endfunction

		function void check_result(input logic [OutTdataW-1:0] tdata);
			frame_result_t w;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: status %0d reading %0d",
						tdata[1:0], $signed(tdata[33:2]));
				end
				return;
			end
			w = awaited.pop_front();
			results_seen++;
			status_count[w.status]++;
			if (tdata[1:0] !== w.status || tdata[33:2] !== w.reading
					|| tdata[OutTdataW-1:34] !== '0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: status exp %0d got %0d, reading exp %0d got %0d, pad %h",
						results_seen, w.status, tdata[1:0], $signed(w.reading),
						$signed(tdata[33:2]), tdata[OutTdataW-1:34]);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OutTdataW-1:0] m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	cfg_index_t           cfg_index;
	logic [7:0]           cfg_data;

	frame_checker chk = new();
	int  src_idle;
	int  sink_idle;
	bit  hold_req;
	int  bytes_sent;
	int  reg_writes;
	int  quiet_cycles = 0;

	crc16_framed_reading_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		chk.note_byte(b);
		bytes_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (chk.awaited.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// leaves cfg_valid high; caller lowers it after the last write
	task automatic cfg_write(input cfg_index_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		chk.set_reg(idx, v);
		reg_writes++;
	endtask

	task automatic finish_frame();
		while (chk.pos != 0) send_byte(8'($urandom));
	endtask

	task automatic send_frame(input frame_kind_t kind, input logic [31:0] value,
			input bit mid_write);
		logic [7:0]  fr[11];
		logic [15:0] c;
		int          hdr_pick;
		int          n;
		hdr_pick = $urandom_range(2);
		fr[0] = chk.want_addr;
		if ((kind == FrBadHeader || kind == FrBadBoth) && hdr_pick != 1) begin
			fr[0] ^= 8'(1 << $urandom_range(7));
		end
		send_byte(fr[0]);
		// function code changes between byte 0 and byte 1 of this frame
		if (mid_write) begin
			drain();
			cfg_write(RegFunc, 8'($urandom));
			cfg_valid <= 1'b0;
		end
		fr[1] = chk.want_func;
		if ((kind == FrBadHeader || kind == FrBadBoth) && hdr_pick != 0) begin
			fr[1] ^= 8'(1 << $urandom_range(7));
		end
		for (int k = 2; k < 5; k++) begin
			fr[k] = 8'($urandom);
		end
		{fr[5], fr[6], fr[7], fr[8]} = value;
		c = CrcInit;
		for (int k = 0; k < 9; k++) begin
			c = frame_checker::crc_step(c, fr[k]);
		end
		fr[9]  = c[7:0];
		fr[10] = c[15:8];
		if (kind == FrBadCrc || kind == FrBadBoth) begin
			fr[9 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
		end
		n = (kind == FrCut) ? $urandom_range(1, 10) : 11;
		for (int k = 1; k < n; k++) begin
			send_byte(fr[k]);
		end
	endtask

	task automatic random_frame();
		int          pick;
		int          n;
		logic [31:0] value;
		pick = $urandom_range(99);
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(3))
				0: value = 32'h8000_0000;
				1: value = 32'h7FFF_FFFF;
				2: value = 32'h0000_0000;
				default: value = 32'hFFFF_FFFF;
			endcase
		end else begin
			value = $urandom;
		end
		if (pick < 58) begin
			send_frame(FrGood, value, 1'b0);
		end else if (pick < 68) begin
			send_frame(FrBadHeader, value, 1'b0);
		end else if (pick < 78) begin
			send_frame(FrBadCrc, value, 1'b0);
		end else if (pick < 86) begin
			send_frame(FrBadBoth, value, 1'b0);
		end else if (pick < 93) begin
			n = $urandom_range(1, 14);
			repeat (n) send_byte(8'($urandom));
			finish_frame();
		end else begin
			send_frame(FrCut, value, 1'b0);
			finish_frame();
		end
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= sink_idle);
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				chk.check_result(m_axis_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WatchdogLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int seg_start;
		hold_req     = 1'b0;
		bytes_sent   = 0;
		reg_writes   = 0;
		src_idle     = 11;
		sink_idle    = 84;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= RegAddr;
		cfg_data      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(FrGood, 32'h8000_0000, 1'b0);
		send_frame(FrGood, 32'h7FFF_FFFF, 1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					src_idle  = 11;
					sink_idle = 84;
				end
				1: begin
					src_idle  = 84;
					sink_idle = 11;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
				end
			endcase
			finish_frame();
			drain();
			case (seg)
				0: begin
					cfg_write(RegAddr, 8'h00);
					cfg_write(RegFunc, 8'h00);
				end
				1: begin
					cfg_write(RegAddr, 8'hFF);
					cfg_write(RegFunc, 8'hFF);
				end
				default: begin
					cfg_write(RegAddr, 8'($urandom));
					cfg_write(RegFunc, 8'($urandom));
				end
			endcase
			cfg_valid <= 1'b0;
			if (seg == 4) begin
				hold_req = 1'b1;
			end
			seg_start = bytes_sent;
			while (bytes_sent - seg_start < SegmentBytes) random_frame();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d bytes sent, %0d register writes, %0d frame results checked",
			bytes_sent, reg_writes, chk.results_seen);
		$display("frame status mix: %0d ok, %0d header error, %0d CRC error",
			chk.status_count[StatusOk], chk.status_count[StatusHeader],
			chk.status_count[StatusCrc]);
		if (chk.mismatches == 0 && chk.awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
